// ===== design/replay_key_filter_defines.svh =====
// Assertion macros used by the replay key filter search sequencer.
`ifndef REPLAY_KEY_FILTER_DEFINES_SVH
`define REPLAY_KEY_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define RKF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("replay_key_filter: assertion failed");
// Checked on every clock edge, reset included.
`define RKF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("replay_key_filter: assertion failed");
`else
`define RKF_ASSERT(lbl, prop)
`define RKF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== design/rkf_pkg.sv =====
// Types and constants of the replay key filter.
package rkf_pkg;

  // Default sizing of the key table
  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned KEY_BITS_DEF    = 64;

  // Fixed field widths
  localparam int unsigned CAP_W    = 7;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned USED_W   = 7;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

  // Request actions
  localparam logic ACT_CHECK   = 1'b0;
  localparam logic ACT_CONSUME = 1'b1;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_FRESH     = 2'd0,
    STATUS_DUPLICATE = 2'd1,
    STATUS_CAPACITY  = 2'd2,
    STATUS_ARGUMENT  = 2'd3
  } status_t;

  // Search sequencer states
  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_RUN,
    SCAN_DONE
  } scan_state_t;

  // One response as handed from the sequencer to the output register
  typedef struct packed {
    status_t             status;
    logic [USED_W-1:0]   entries_used;
  } result_t;

endpackage

// ===== design/rkf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rkf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rkf_scan.sv =====
// Search sequencer: walks the key table one read per cycle and appends keys.
`include "replay_key_filter_defines.svh"

module rkf_scan #(
  parameter int unsigned TABLE_DEPTH = rkf_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_BITS    = rkf_pkg::KEY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic                       action,
  input  logic [KEY_BITS-1:0]        key,
  input  logic                       encode_failed,
  input  logic [rkf_pkg::CAP_W-1:0]  capacity,
  input  logic                       cfg_clear,
  input  logic                       out_free,
  output logic                       done,
  output rkf_pkg::result_t           result
);

  localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW     = (CNT_W > rkf_pkg::CAP_W) ? CNT_W : rkf_pkg::CAP_W;
  localparam int unsigned EW     = CNT_W + rkf_pkg::USED_W;

  rkf_pkg::scan_state_t state, state_next;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    idx;
  logic [KEY_BITS-1:0] key_reg;
  logic                action_reg;
  logic                failed_reg;
  logic                hit;
  logic                rd_pend;

  logic                accept;
  logic                mem_re;
  logic                mem_we;
  logic                match;
  logic                full;
  logic                store_ok;
  logic [KEY_BITS-1:0] rd_data;
  logic [CW-1:0]       usable;
  logic [CW-1:0]       cap_ext;
  logic [CNT_W-1:0]    count_next;
  logic [EW-1:0]       used_wide;

  // Key table
  rkf_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_key_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (key_reg),
    .re    (mem_re),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // Usable capacity is the register clipped to the table depth
  always_comb begin
    cap_ext = CW'(capacity);
    usable  = (cap_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cap_ext;
    full    = CW'(count) >= usable;
  end

  assign match = rd_pend && (rd_data == key_reg);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rkf_pkg::SCAN_IDLE: begin
        if (req_valid) begin
          // failed encodings and an empty table skip the search
          if (encode_failed || (count == '0)) begin
            state_next = rkf_pkg::SCAN_DONE;
          end else begin
            state_next = rkf_pkg::SCAN_RUN;
          end
        end
      end
      rkf_pkg::SCAN_RUN: begin
        if (match || (!mem_re && !rd_pend)) begin
          state_next = rkf_pkg::SCAN_DONE;
        end
      end
      rkf_pkg::SCAN_DONE: begin
        if (out_free) begin
          state_next = rkf_pkg::SCAN_IDLE;
        end
      end
      default: state_next = rkf_pkg::SCAN_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    req_stall = (state != rkf_pkg::SCAN_IDLE);
    accept    = (state == rkf_pkg::SCAN_IDLE) && req_valid;
    mem_re    = (state == rkf_pkg::SCAN_RUN) && (idx < count) && !hit;
    done      = (state == rkf_pkg::SCAN_DONE) && out_free;
    store_ok  = !failed_reg && !hit && (action_reg == rkf_pkg::ACT_CONSUME) && !full;
    mem_we    = done && store_ok;
  end

  // Response fields
  always_comb begin
    count_next = mem_we ? (count + CNT_W'(1)) : count;
    used_wide  = EW'(count_next);
    result.entries_used = used_wide[rkf_pkg::USED_W-1:0];
    if (failed_reg) begin
      result.status = rkf_pkg::STATUS_ARGUMENT;
    end else if (hit) begin
      result.status = rkf_pkg::STATUS_DUPLICATE;
    end else if (action_reg == rkf_pkg::ACT_CHECK) begin
      result.status = rkf_pkg::STATUS_FRESH;
    end else if (full) begin
      result.status = rkf_pkg::STATUS_CAPACITY;
    end else begin
      result.status = rkf_pkg::STATUS_FRESH;
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rkf_pkg::SCAN_IDLE;
      count   <= '0;
      rd_pend <= 1'b0;
      hit     <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= mem_re;
      if (cfg_clear) begin
        count <= '0;
      end else if (mem_we) begin
        count <= count_next;
      end
      if (accept) begin
        hit <= 1'b0;
      end else if ((state == rkf_pkg::SCAN_RUN) && match) begin
        hit <= 1'b1;
      end
    end
  end

  // Request capture and read pointer
  always_ff @(posedge clk) begin
    if (accept) begin
      key_reg    <= key;
      action_reg <= action;
      failed_reg <= encode_failed;
      idx        <= '0;
    end else if (mem_re) begin
      idx <= idx + CNT_W'(1);
    end
  end

  `RKF_ASSERT(a_count_in_range, count <= CNT_W'(TABLE_DEPTH))
  `RKF_ASSERT(a_no_read_during_write, !(mem_we && mem_re))
  `RKF_ASSERT(a_append_below_capacity, mem_we |-> (CW'(count) < usable))
  `RKF_ASSERT(a_append_bumps_count, (mem_we && !cfg_clear) |=> (count == $past(count) + 1'b1))
  `RKF_ASSERT(a_pending_follows_read, rd_pend |-> $past(mem_re))

endmodule

// ===== design/replay_key_filter.sv =====
// Replay key filter top level: capacity register, search sequencer, response register.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------
//   req     | in        | req_valid / req_stall | action, key_value, encode_failed
//   rsp     | out       | rsp_valid / rsp_stall | status, entries_used
//   cfg     | in        | capacity_we           | capacity_limit
//
// A request compares its key against the used entries in order; the key table
// gives one read per cycle. A duplicate ends the search at the matching entry;
// encode failures and an empty table skip it. rsp holds one finished response;
// the next request is accepted while it waits, and its search stalls only at
// the end if rsp is still full. rst is synchronous: empty table, capacity 64,
// no response pending.
module replay_key_filter #(
  parameter int unsigned TABLE_DEPTH = rkf_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_BITS    = rkf_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          action,
  input  logic [rkf_pkg::KEY_W-1:0]     key_value,
  input  logic                          encode_failed,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [rkf_pkg::STATUS_W-1:0]  status,
  output logic [rkf_pkg::USED_W-1:0]    entries_used,
  input  logic                          capacity_we,
  input  logic [rkf_pkg::CAP_W-1:0]     capacity_limit
);

  logic [rkf_pkg::CAP_W-1:0] capacity;
  logic                      out_free;
  logic                      done;
  rkf_pkg::result_t          result;
  rkf_pkg::result_t          rsp;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= rkf_pkg::CAPACITY_RESET;
    end else if (capacity_we) begin
      capacity <= capacity_limit;
    end
  end

  assign out_free = !rsp_valid || !rsp_stall;

  // Search and append
  rkf_scan #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .action        (action),
    .key           (key_value[KEY_BITS-1:0]),
    .encode_failed (encode_failed),
    .capacity      (capacity),
    .cfg_clear     (capacity_we),
    .out_free      (out_free),
    .done          (done),
    .result        (result)
  );

  // Response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (done) begin
      rsp <= result;
    end
  end

  assign status       = rsp.status;
  assign entries_used = rsp.entries_used;

endmodule
